// ===== rtl/core/nearest_palette_color_search_top_assert.svh =====
// Assertion macros for the nearest palette color search block.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_TOP_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define NPCS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("npcs assertion failed");
`define NPCS_ASSERT_NEXT(label, cond, expect_next) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |=> (expect_next)) else $error("npcs assertion failed");
`else
`define NPCS_ASSERT(label, prop)
`define NPCS_ASSERT_NEXT(label, cond, expect_next)
`endif
`endif

// ===== rtl/core/npcs_pkg.sv =====
// Types and constants of the nearest palette color search block.
`default_nettype none
package npcs_pkg;
   localparam int CHANNEL_BITS = 8;
   localparam int INDEX_BITS = 8;
   localparam int COUNT_BITS = 9;
   localparam int DIST_BITS = 10;
   localparam int INDEX_SPAN = 256;
   localparam logic [COUNT_BITS-1:0] ENTRIES_RESET = 9'd256;
   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

   typedef enum logic {
      ACTION_WRITE = 1'b0,
      ACTION_LOOKUP = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;
endpackage
`default_nettype wire

// ===== rtl/core/nearest_palette_color_search_top.sv =====
// Nearest palette color search: palette memory, scan sequencer and distance unit.
//
// req channel: one word per item. tuser is the action (write an entry or look
// up a color), tdata carries the entry index and the R, G, B channels.
// A write gives no rsp word; an index not below PALETTE_ENTRIES is dropped.
// A lookup scans entries 0..n-1, n = entries_in_use clamped to 1..min(256,
// PALETTE_ENTRIES), one palette read per cycle through the single read port,
// and a shared distance/compare unit picks the first entry at least distance.
// The read data and the distance are registered before the compare; req_tready is low
// from acceptance until the result enters the rsp register, so lookups do not overlap.
// A finished result waits in the rsp register; a stalled receiver holds it
// there, and the block goes on taking writes. A further lookup scans, then
// waits at its end until the rsp register is free.
// csr channel writes entries_in_use (always ready); write it while idle.
// Reset (synchronous, active high) sets entries_in_use to 256 and empties the
// rsp register; palette contents are undefined until written.
`default_nettype none
`include "nearest_palette_color_search_top_assert.svh"
module nearest_palette_color_search_top #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // entry_index[7:0], red, green, blue
   input  wire logic        req_tuser,  // action[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // nearest_index[7:0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [8:0]  csr_data    // entries_in_use[8:0]
);
   import npcs_pkg::*;

   localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int CW = ((AW > INDEX_BITS) ? AW : INDEX_BITS) + 1;
   localparam int SCAN_LIM = (PALETTE_ENTRIES < INDEX_SPAN) ? PALETTE_ENTRIES : INDEX_SPAN;

   logic [3*CHANNEL_BITS-1:0] mem [PALETTE_ENTRIES];

   logic [INDEX_BITS-1:0]   entry_index;
   logic [CHANNEL_BITS-1:0] red, green, blue;
   logic                    req_accept;
   logic [CW-1:0]           wr_wide;
   logic                    wr_en;
   logic                    rd_en;

   state_type               state_ff, state_in;
   logic [COUNT_BITS-1:0]   entries_ff;
   logic [COUNT_BITS-1:0]   n_ff, n_in, lim;
   logic [INDEX_BITS-1:0]   addr_ff, addr_in;
   logic [3*CHANNEL_BITS-1:0] color_ff, color_in;
   logic [3*CHANNEL_BITS-1:0] rdata_ff;
   logic                    rd_vld_ff, rd_last_ff;
   logic [INDEX_BITS-1:0]   rd_idx_ff;
   logic [DIST_BITS-1:0]    dist_ff, dist_in;
   logic                    dist_vld_ff, dist_last_ff;
   logic [INDEX_BITS-1:0]   dist_idx_ff;
   logic [DIST_BITS-1:0]    best_dist_ff, best_dist_in;
   logic [INDEX_BITS-1:0]   best_idx_ff, best_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0]   rsp_data_ff, rsp_data_in;
   logic                    scan_last;

   function automatic logic [CHANNEL_BITS-1:0] abs_diff(
      input logic [CHANNEL_BITS-1:0] a,
      input logic [CHANNEL_BITS-1:0] b
   );
      return (a > b) ? (a - b) : (b - a);
   endfunction

   assign entry_index = req_tdata[7:0];
   assign red         = req_tdata[15:8];
   assign green       = req_tdata[23:16];
   assign blue        = req_tdata[31:24];
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign wr_wide     = CW'(entry_index);
   assign wr_en       = req_accept && (req_tuser == ACTION_WRITE)
                        && (wr_wide < CW'(PALETTE_ENTRIES));
   assign rd_en       = (state_ff == ST_SCAN);
   assign scan_last   = ({1'b0, addr_ff} == (n_ff - 9'd1));
   assign csr_ready   = 1'b1;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;

   always_comb begin
      lim = entries_ff;
      if (lim == '0) begin
         lim = 9'd1;
      end
      if (lim > COUNT_BITS'(SCAN_LIM)) begin
         lim = COUNT_BITS'(SCAN_LIM);
      end
   end

   // distance unit
   assign dist_in = DIST_BITS'(abs_diff(color_ff[23:16], rdata_ff[23:16]))
                  + DIST_BITS'(abs_diff(color_ff[15:8], rdata_ff[15:8]))
                  + DIST_BITS'(abs_diff(color_ff[7:0], rdata_ff[7:0]));

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      addr_in      = addr_ff;
      color_in     = color_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (dist_vld_ff && (dist_ff < best_dist_ff)) begin
         best_dist_in = dist_ff;
         best_idx_in  = dist_idx_ff;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == ACTION_LOOKUP)) begin
               n_in         = lim;
               addr_in      = '0;
               color_in     = {red, green, blue};
               best_dist_in = DIST_MAX;
               best_idx_in  = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + 8'd1;
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (dist_vld_ff && dist_last_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = best_idx_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_wide[AW-1:0]] <= {red, green, blue};
      end
      if (rd_en) begin
         rdata_ff <= mem[AW'(addr_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         entries_ff   <= ENTRIES_RESET;
         rd_vld_ff    <= 1'b0;
         dist_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_en;
         dist_vld_ff  <= rd_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            entries_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      addr_ff      <= addr_in;
      color_ff     <= color_in;
      rd_last_ff   <= scan_last;
      rd_idx_ff    <= addr_ff;
      dist_ff      <= dist_in;
      dist_last_ff <= rd_last_ff;
      dist_idx_ff  <= rd_idx_ff;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end

   `NPCS_ASSERT_NEXT(a_lookup_starts_scan, req_accept && (req_tuser == ACTION_LOOKUP),
      (state_ff == ST_SCAN) && (addr_ff == '0))
   `NPCS_ASSERT(a_dist_only_in_scan, dist_vld_ff |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
   `NPCS_ASSERT(a_finish_drained, (state_ff == ST_FINISH) |-> (!rd_vld_ff && !dist_vld_ff))
   `NPCS_ASSERT(a_rsp_from_finish, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
endmodule
`default_nettype wire
